// ----- rtl/trle_pkg.sv -----
// ----------------------------------------------------------------------------
// trle_pkg: shared types and constants of the thick line raster engine
// Holds the command record that moves from the front end to the back end,
// the register and command codes, and the back-end state type.
// ----------------------------------------------------------------------------
`default_nettype none

package trle_pkg;

  // Default sizes of the frame store and the largest stamp.
  localparam int unsigned DEF_MAX_RASTER_WIDTH  = 256;
  localparam int unsigned DEF_MAX_RASTER_HEIGHT = 256;
  localparam int unsigned DEF_MAX_HALF_WIDTH    = 7;

  // Field widths fixed by the item format.
  localparam int unsigned COORD_W = 12;
  localparam int unsigned CFG_W   = 9;
  localparam int unsigned COLOR_W = 32;
  localparam int unsigned FLOW_W  = 8;
  localparam int unsigned RD_W    = 8;
  localparam int unsigned SHW_W   = 3;
  // Half width after clamping; wide enough for the largest allowed maximum.
  localparam int unsigned HW_W    = 5;
  // One frame store word holds color and flow side by side.
  localparam int unsigned PIX_W   = COLOR_W + FLOW_W;

  // Depth of the command queue between front and back end (power of two).
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    CMD_DRAW = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_RASTER_WIDTH  = 1'b0,
    REG_RASTER_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_STAMP,
    BK_READ_MEM,
    BK_READ_WAIT
  } bk_state_e;

  // Classified command as it waits in the queue.
  typedef struct packed {
    logic                       is_read;
    logic                       read_hit;
    logic signed [COORD_W-1:0]  x0;
    logic signed [COORD_W-1:0]  y0;
    logic signed [COORD_W-1:0]  x1;
    logic signed [COORD_W-1:0]  y1;
    logic [COLOR_W-1:0]         color;
    logic [FLOW_W-1:0]          flow;
    logic [HW_W-1:0]            hw;
    logic [RD_W-1:0]            rx;
    logic [RD_W-1:0]            ry;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/trle_ram.sv -----
// ----------------------------------------------------------------------------
// trle_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module trle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/trle_front.sv -----
// ----------------------------------------------------------------------------
// trle_front: input side of the thick line raster engine
// Accepts items, clamps the stamp size, decides whether a read hits the
// raster, and pushes the classified command into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module trle_front #(
  parameter int unsigned MAX_RASTER_WIDTH  = trle_pkg::DEF_MAX_RASTER_WIDTH,
  parameter int unsigned MAX_RASTER_HEIGHT = trle_pkg::DEF_MAX_RASTER_HEIGHT,
  parameter int unsigned MAX_HALF_WIDTH    = trle_pkg::DEF_MAX_HALF_WIDTH
) (
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                command_i,
  input  wire logic signed [trle_pkg::COORD_W-1:0] start_x_i,
  input  wire logic signed [trle_pkg::COORD_W-1:0] start_y_i,
  input  wire logic signed [trle_pkg::COORD_W-1:0] end_x_i,
  input  wire logic signed [trle_pkg::COORD_W-1:0] end_y_i,
  input  wire logic [trle_pkg::COLOR_W-1:0]        line_color_i,
  input  wire logic [trle_pkg::FLOW_W-1:0]         line_flow_i,
  input  wire logic [trle_pkg::SHW_W-1:0]          stamp_half_width_i,
  input  wire logic [trle_pkg::RD_W-1:0]           read_x_i,
  input  wire logic [trle_pkg::RD_W-1:0]           read_y_i,
  input  wire logic [trle_pkg::CFG_W-1:0]          raster_width_i,
  input  wire logic [trle_pkg::CFG_W-1:0]          raster_height_i,
  input  wire logic                                q_full_i,
  input  wire logic                                clearing_i,
  output logic                                     push_o,
  output trle_pkg::cmd_t                           cmd_o
);

  import trle_pkg::*;

  localparam logic [12:0]     MAXW_C = 13'(MAX_RASTER_WIDTH);
  localparam logic [12:0]     MAXH_C = 13'(MAX_RASTER_HEIGHT);
  localparam logic [HW_W-1:0] MAXHW_C = HW_W'(MAX_HALF_WIDTH);

  logic [HW_W-1:0] hw_raw;
  logic            hit_x;
  logic            hit_y;

  // Stall while the queue is full or the frame store is being cleared.
  assign in_stall_o = q_full_i | clearing_i;
  assign push_o     = in_valid_i & ~in_stall_o;

  // A read hits when its address lies inside both the raster and the store.
  assign hit_x = ({5'b0, read_x_i} < MAXW_C) && ({1'b0, read_x_i} < raster_width_i);
  assign hit_y = ({5'b0, read_y_i} < MAXH_C) && ({1'b0, read_y_i} < raster_height_i);

  // Clamp the half width to the largest stamp the block supports.
  assign hw_raw = HW_W'(stamp_half_width_i);

  // Build the command record.
  always_comb begin
    cmd_o          = '0;
    cmd_o.is_read  = (cmd_e'(command_i) == CMD_READ);
    cmd_o.read_hit = hit_x & hit_y;
    cmd_o.x0       = start_x_i;
    cmd_o.y0       = start_y_i;
    cmd_o.x1       = end_x_i;
    cmd_o.y1       = end_y_i;
    cmd_o.color    = line_color_i;
    cmd_o.flow     = line_flow_i;
    cmd_o.hw       = (hw_raw > MAXHW_C) ? MAXHW_C : hw_raw;
    cmd_o.rx       = read_x_i;
    cmd_o.ry       = read_y_i;
  end

endmodule

`default_nettype wire

// ----- rtl/trle_queue.sv -----
// ----------------------------------------------------------------------------
// trle_queue: command queue between front end and back end
// A short register FIFO of classified commands, so either side can stall
// without holding up the other.
// ----------------------------------------------------------------------------
`default_nettype none

module trle_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  trle_pkg::cmd_t      cmd_i,
  output logic                full_o,
  output logic                valid_o,
  input  wire logic           pop_i,
  output trle_pkg::cmd_t      cmd_o
);

  import trle_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rptr_q];

  // Pointer and fill count update.
  always_comb begin
    wptr_d = push_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop_i ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/trle_back.sv -----
// ----------------------------------------------------------------------------
// trle_back: execution side of the thick line raster engine
// Clears the frame store after reset, walks Bresenham lines while scanning
// the square stamp at each point one pixel per cycle, and serves reads.
// ----------------------------------------------------------------------------
`default_nettype none

module trle_back #(
  parameter int unsigned MAX_RASTER_WIDTH  = trle_pkg::DEF_MAX_RASTER_WIDTH,
  parameter int unsigned MAX_RASTER_HEIGHT = trle_pkg::DEF_MAX_RASTER_HEIGHT
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [trle_pkg::CFG_W-1:0]   raster_width_i,
  input  wire logic [trle_pkg::CFG_W-1:0]   raster_height_i,
  input  wire logic                         q_valid_i,
  input  trle_pkg::cmd_t                    q_cmd_i,
  output logic                              q_pop_o,
  output logic                              clearing_o,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [trle_pkg::COLOR_W-1:0]      pixel_color_o,
  output logic [trle_pkg::FLOW_W-1:0]       pixel_flow_o
);

  import trle_pkg::*;

  localparam int unsigned DEPTH  = MAX_RASTER_WIDTH * MAX_RASTER_HEIGHT;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);
  localparam logic [12:0] MAXW_C = 13'(MAX_RASTER_WIDTH);
  localparam logic [12:0] MAXH_C = 13'(MAX_RASTER_HEIGHT);

  bk_state_e state_q, state_d;

  logic [ADDR_W-1:0]         clr_q, clr_d;
  logic signed [COORD_W-1:0] x_q, x_d, y_q, y_d, x1_q, x1_d, y1_q, y1_d;
  logic [COORD_W-1:0]        dx_q, dx_d, dy_q, dy_d;
  logic                      sxn_q, sxn_d, syn_q, syn_d;
  logic signed [14:0]        err_q, err_d;
  logic signed [5:0]         ox_q, ox_d, oy_q, oy_d;
  logic [HW_W-1:0]           hw_q, hw_d;
  logic [COLOR_W-1:0]        color_q, color_d;
  logic [FLOW_W-1:0]         flow_q, flow_d;
  logic [ADDR_W-1:0]         rd_addr_q, rd_addr_d;
  logic                      wr_vld_q, wr_vld_d;
  logic [ADDR_W-1:0]         wr_addr_q, wr_addr_d;
  logic [PIX_W-1:0]          wr_data_q, wr_data_d;
  logic                      out_vld_q, out_vld_d;
  logic [COLOR_W-1:0]        out_color_q, out_color_d;
  logic [FLOW_W-1:0]         out_flow_q, out_flow_d;

  logic                      ram_re;
  logic [PIX_W-1:0]          ram_rdata;

  logic signed [5:0]         hw_s;
  logic signed [13:0]        px, py;
  logic                      px_in, py_in;
  logic                      last_col, last_row, at_end;
  logic signed [15:0]        e2, dx16, ndy16;
  logic                      step_x, step_y;
  logic signed [14:0]        err_nx;
  logic signed [12:0]        sdx, sdy;
  logic [COORD_W-1:0]        adx, ady;

  // Current stamp pixel and its clipping against raster and store.
  assign hw_s  = $signed({1'b0, hw_q});
  assign px    = $signed({{2{x_q[COORD_W-1]}}, x_q}) + $signed({{8{ox_q[5]}}, ox_q});
  assign py    = $signed({{2{y_q[COORD_W-1]}}, y_q}) + $signed({{8{oy_q[5]}}, oy_q});
  assign px_in = !px[13] && (px[12:0] < MAXW_C) && (px[12:0] < {4'b0, raster_width_i});
  assign py_in = !py[13] && (py[12:0] < MAXH_C) && (py[12:0] < {4'b0, raster_height_i});

  assign last_col = (ox_q == hw_s);
  assign last_row = (oy_q == hw_s);
  assign at_end   = (x_q == x1_q) && (y_q == y1_q);

  // Bresenham error step toward the next line point.
  assign e2     = {err_q, 1'b0};
  assign dx16   = $signed({4'b0, dx_q});
  assign ndy16  = -$signed({4'b0, dy_q});
  assign step_x = (e2 > ndy16);
  assign step_y = (e2 < dx16);
  assign err_nx = err_q - (step_x ? $signed({3'b0, dy_q}) : 15'sd0)
                        + (step_y ? $signed({3'b0, dx_q}) : 15'sd0);

  // Line setup from the command at the head of the queue.
  assign sdx = $signed({q_cmd_i.x1[COORD_W-1], q_cmd_i.x1})
             - $signed({q_cmd_i.x0[COORD_W-1], q_cmd_i.x0});
  assign sdy = $signed({q_cmd_i.y1[COORD_W-1], q_cmd_i.y1})
             - $signed({q_cmd_i.y0[COORD_W-1], q_cmd_i.y0});
  assign adx = sdx[12] ? COORD_W'(-sdx) : sdx[COORD_W-1:0];
  assign ady = sdy[12] ? COORD_W'(-sdy) : sdy[COORD_W-1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_CLEAR: begin
        if (clr_q == CLR_LAST) begin
          state_d = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (q_valid_i) begin
          if (!q_cmd_i.is_read) begin
            state_d = BK_STAMP;
          end else if (!out_vld_q && q_cmd_i.read_hit) begin
            state_d = BK_READ_MEM;
          end
        end
      end
      BK_STAMP: begin
        if (last_col && last_row && at_end) begin
          state_d = BK_IDLE;
        end
      end
      BK_READ_MEM:  state_d = BK_READ_WAIT;
      BK_READ_WAIT: state_d = BK_IDLE;
      default:      state_d = BK_IDLE;
    endcase
  end

  // Outputs and datapath updates.
  always_comb begin
    clr_d       = clr_q;
    x_d         = x_q;
    y_d         = y_q;
    x1_d        = x1_q;
    y1_d        = y1_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    sxn_d       = sxn_q;
    syn_d       = syn_q;
    err_d       = err_q;
    ox_d        = ox_q;
    oy_d        = oy_q;
    hw_d        = hw_q;
    color_d     = color_q;
    flow_d      = flow_q;
    rd_addr_d   = rd_addr_q;
    wr_vld_d    = 1'b0;
    wr_addr_d   = wr_addr_q;
    wr_data_d   = wr_data_q;
    out_vld_d   = out_vld_q & out_stall_i;
    out_color_d = out_color_q;
    out_flow_d  = out_flow_q;
    q_pop_o     = 1'b0;
    ram_re      = 1'b0;
    case (state_q)
      BK_CLEAR: begin
        wr_vld_d  = 1'b1;
        wr_addr_d = clr_q;
        wr_data_d = '0;
        clr_d     = clr_q + 1'b1;
      end
      BK_IDLE: begin
        if (q_valid_i) begin
          if (!q_cmd_i.is_read) begin
            // Load the line walker and start the first stamp.
            q_pop_o = 1'b1;
            x_d     = q_cmd_i.x0;
            y_d     = q_cmd_i.y0;
            x1_d    = q_cmd_i.x1;
            y1_d    = q_cmd_i.y1;
            dx_d    = adx;
            dy_d    = ady;
            sxn_d   = !(q_cmd_i.x0 < q_cmd_i.x1);
            syn_d   = !(q_cmd_i.y0 < q_cmd_i.y1);
            err_d   = $signed({3'b0, adx}) - $signed({3'b0, ady});
            hw_d    = q_cmd_i.hw;
            ox_d    = -$signed({1'b0, q_cmd_i.hw});
            oy_d    = -$signed({1'b0, q_cmd_i.hw});
            color_d = q_cmd_i.color;
            flow_d  = q_cmd_i.flow;
          end else if (!out_vld_q) begin
            q_pop_o   = 1'b1;
            rd_addr_d = ADDR_W'(int'(q_cmd_i.ry) * MAX_RASTER_WIDTH + int'(q_cmd_i.rx));
            if (!q_cmd_i.read_hit) begin
              // Off-raster reads answer zero without touching the store.
              out_vld_d   = 1'b1;
              out_color_d = '0;
              out_flow_d  = '0;
            end
          end
        end
      end
      BK_STAMP: begin
        wr_vld_d  = px_in & py_in;
        wr_addr_d = ADDR_W'(int'(py[12:0]) * MAX_RASTER_WIDTH + int'(px[12:0]));
        wr_data_d = {color_q, flow_q};
        if (last_col) begin
          ox_d = -hw_s;
          if (last_row) begin
            // Stamp done: move to the next line point.
            oy_d = -hw_s;
            if (!at_end) begin
              err_d = err_nx;
              if (step_x) begin
                x_d = sxn_q ? x_q - 1'b1 : x_q + 1'b1;
              end
              if (step_y) begin
                y_d = syn_q ? y_q - 1'b1 : y_q + 1'b1;
              end
            end
          end else begin
            oy_d = oy_q + 1'b1;
          end
        end else begin
          ox_d = ox_q + 1'b1;
        end
      end
      BK_READ_MEM: begin
        ram_re = 1'b1;
      end
      BK_READ_WAIT: begin
        out_vld_d   = 1'b1;
        out_color_d = ram_rdata[PIX_W-1:FLOW_W];
        out_flow_d  = ram_rdata[FLOW_W-1:0];
      end
      default: begin
        q_pop_o = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_CLEAR;
      clr_q     <= '0;
      wr_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      wr_vld_q  <= wr_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    x_q         <= x_d;
    y_q         <= y_d;
    x1_q        <= x1_d;
    y1_q        <= y1_d;
    dx_q        <= dx_d;
    dy_q        <= dy_d;
    sxn_q       <= sxn_d;
    syn_q       <= syn_d;
    err_q       <= err_d;
    ox_q        <= ox_d;
    oy_q        <= oy_d;
    hw_q        <= hw_d;
    color_q     <= color_d;
    flow_q      <= flow_d;
    rd_addr_q   <= rd_addr_d;
    wr_addr_q   <= wr_addr_d;
    wr_data_q   <= wr_data_d;
    out_color_q <= out_color_d;
    out_flow_q  <= out_flow_d;
  end

  // Frame store: color and flow mark in one word.
  trle_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_vld_q),
    .waddr_i (wr_addr_q),
    .wdata_i (wr_data_q),
    .re_i    (ram_re),
    .raddr_i (rd_addr_q),
    .rdata_o (ram_rdata)
  );

  assign clearing_o    = (state_q == BK_CLEAR);
  assign out_valid_o   = out_vld_q;
  assign pixel_color_o = out_color_q;
  assign pixel_flow_o  = out_flow_q;

endmodule

`default_nettype wire

// ----- rtl/thick_line_raster_engine.sv -----
// ----------------------------------------------------------------------------
// thick_line_raster_engine: thick line rasterizer over a color/flow store
// Draws Bresenham lines stamped with a square brush and reads pixels back.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the input channel (in_valid_i / in_stall_o). A draw item
//   gives no result; a read item gives one result on the output channel
//   (out_valid_o / out_stall_i) carrying the stored color and flow mark.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) set the raster
//   size; the user must make them only while the block is idle, which the
//   block does not enforce. Items pass through a two-entry queue; the back
//   end runs one at a time. A draw stamps (2 * h + 1)^2 pixels at each of P
//   line points, where P is the larger of |dx| and |dy|, plus one, and h the
//   clamped half width: the single write port of the frame store takes one
//   pixel a cycle. With the back end free, a read that hits the raster
//   offers its result after passing the queue, the pop, the memory access
//   and the registered read data; a read off the raster answers zero from
//   the output register. After reset the frame store is cleared one word a
//   cycle, all MAX_RASTER_WIDTH * MAX_RASTER_HEIGHT words (65536 by default); the
//   input is stalled during that pass. A stalled result holds in the output
//   register; the queue keeps taking items until it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module thick_line_raster_engine #(
  parameter int unsigned MAX_RASTER_WIDTH  = trle_pkg::DEF_MAX_RASTER_WIDTH,
  parameter int unsigned MAX_RASTER_HEIGHT = trle_pkg::DEF_MAX_RASTER_HEIGHT,
  parameter int unsigned MAX_HALF_WIDTH    = trle_pkg::DEF_MAX_HALF_WIDTH
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic                                cfg_idx_i,
  input  wire logic [trle_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                command_i,
  input  wire logic signed [trle_pkg::COORD_W-1:0] start_x_i,
  input  wire logic signed [trle_pkg::COORD_W-1:0] start_y_i,
  input  wire logic signed [trle_pkg::COORD_W-1:0] end_x_i,
  input  wire logic signed [trle_pkg::COORD_W-1:0] end_y_i,
  input  wire logic [trle_pkg::COLOR_W-1:0]        line_color_i,
  input  wire logic [trle_pkg::FLOW_W-1:0]         line_flow_i,
  input  wire logic [trle_pkg::SHW_W-1:0]          stamp_half_width_i,
  input  wire logic [trle_pkg::RD_W-1:0]           read_x_i,
  input  wire logic [trle_pkg::RD_W-1:0]           read_y_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [trle_pkg::COLOR_W-1:0]             pixel_color_o,
  output logic [trle_pkg::FLOW_W-1:0]              pixel_flow_o
);

  import trle_pkg::*;

  logic [CFG_W-1:0] raster_width_q;
  logic [CFG_W-1:0] raster_height_q;
  logic             q_full, q_valid, q_push, q_pop, clearing;
  cmd_t             front_cmd, q_cmd;

  // Raster size registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raster_width_q  <= CFG_W'(256);
      raster_height_q <= CFG_W'(256);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_RASTER_WIDTH:  raster_width_q  <= cfg_wdata_i;
        REG_RASTER_HEIGHT: raster_height_q <= cfg_wdata_i;
        default:           raster_width_q  <= raster_width_q;
      endcase
    end
  end

  // Front end: accept and classify.
  trle_front #(
    .MAX_RASTER_WIDTH  (MAX_RASTER_WIDTH),
    .MAX_RASTER_HEIGHT (MAX_RASTER_HEIGHT),
    .MAX_HALF_WIDTH    (MAX_HALF_WIDTH)
  ) u_front (
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .start_x_i          (start_x_i),
    .start_y_i          (start_y_i),
    .end_x_i            (end_x_i),
    .end_y_i            (end_y_i),
    .line_color_i       (line_color_i),
    .line_flow_i        (line_flow_i),
    .stamp_half_width_i (stamp_half_width_i),
    .read_x_i           (read_x_i),
    .read_y_i           (read_y_i),
    .raster_width_i     (raster_width_q),
    .raster_height_i    (raster_height_q),
    .q_full_i           (q_full),
    .clearing_i         (clearing),
    .push_o             (q_push),
    .cmd_o              (front_cmd)
  );

  // Command queue.
  trle_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .cmd_o   (q_cmd)
  );

  // Back end: line walker, stamp scanner and frame store.
  trle_back #(
    .MAX_RASTER_WIDTH  (MAX_RASTER_WIDTH),
    .MAX_RASTER_HEIGHT (MAX_RASTER_HEIGHT)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .raster_width_i  (raster_width_q),
    .raster_height_i (raster_height_q),
    .q_valid_i       (q_valid),
    .q_cmd_i         (q_cmd),
    .q_pop_o         (q_pop),
    .clearing_o      (clearing),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pixel_color_o   (pixel_color_o),
    .pixel_flow_o    (pixel_flow_o)
  );

endmodule

`default_nettype wire

// ----- rtl/trle_checker.sv -----
// ----------------------------------------------------------------------------
// trle_checker: port-level checks for the thick line raster engine
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module trle_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_stall_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic [trle_pkg::COLOR_W-1:0] pixel_color_o,
  input wire logic [trle_pkg::FLOW_W-1:0]  pixel_flow_o
);

  // The store clear starts at reset, so the input stalls right after it.
  assert property (@(posedge clk_i) !rst_ni |=> in_stall_o)
    else $error("input not stalled after reset");

  // Reset empties the output register.
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid right after reset");

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result dropped");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(pixel_color_o) && $stable(pixel_flow_o))
    else $error("stalled result payload changed");

endmodule

bind thick_line_raster_engine trle_checker u_trle_checker (.*);

`default_nettype wire

// ----- sim/thick_line_raster_engine_test.sv -----
// ----------------------------------------------------------------------------
// thick_line_raster_engine_test: self-checking bench for the line rasterizer
// Drives draw and read items with random idling on both channels, keeps its
// own image of the color and flow stores, and compares each read result with
// the pixel that the image holds. The raster size is changed between phases,
// including empty, single-pixel and oversized settings.
// ----------------------------------------------------------------------------

module thick_line_raster_engine_test;
  import trle_pkg::*;

  localparam longint CLK_PERIOD     = 12;
  localparam longint TIMEOUT_CYCLES = 10_000_000;
  localparam int     STORE_WORDS    = int'(DEF_MAX_RASTER_WIDTH * DEF_MAX_RASTER_HEIGHT);
  localparam int     PHASES         = 10;
  localparam int     PHASE_ITEMS    = 130;

  // One item as it is offered on the input channel.
  typedef struct {
    cmd_e                      command;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic [COLOR_W-1:0]        color;
    logic [FLOW_W-1:0]         flow;
    logic [SHW_W-1:0]          brush_hw;
    logic [RD_W-1:0]           read_x;
    logic [RD_W-1:0]           read_y;
  } raster_item_t;

  // Color and flow mark of one pixel as a read returns them.
  typedef struct {
    logic [COLOR_W-1:0] color;
    logic [FLOW_W-1:0]  flow;
  } pixel_t;

  // A recently drawn line, used to aim reads at covered pixels.
  typedef struct {
    int x0;
    int y0;
    int x1;
    int y1;
    int hw;
  } stroke_t;

  logic                      clk_i              = 1'b0;
  logic                      rst_ni             = 1'b0;
  logic                      cfg_we_i           = 1'b0;
  logic                      cfg_idx_i          = 1'b0;
  logic [CFG_W-1:0]          cfg_wdata_i        = '0;
  logic                      in_valid_i         = 1'b0;
  logic                      in_stall_o;
  logic                      command_i          = 1'b0;
  logic signed [COORD_W-1:0] start_x_i          = '0;
  logic signed [COORD_W-1:0] start_y_i          = '0;
  logic signed [COORD_W-1:0] end_x_i            = '0;
  logic signed [COORD_W-1:0] end_y_i            = '0;
  logic [COLOR_W-1:0]        line_color_i       = '0;
  logic [FLOW_W-1:0]         line_flow_i        = '0;
  logic [SHW_W-1:0]          stamp_half_width_i = '0;
  logic [RD_W-1:0]           read_x_i           = '0;
  logic [RD_W-1:0]           read_y_i           = '0;
  logic                      out_valid_o;
  logic                      out_stall_i        = 1'b0;
  logic [COLOR_W-1:0]        pixel_color_o;
  logic [FLOW_W-1:0]         pixel_flow_o;

  // Image of the frame store and the raster size as the block should hold them.
  bit [COLOR_W-1:0] color_img [STORE_WORDS];
  bit [FLOW_W-1:0]  flow_img  [STORE_WORDS];
  logic [CFG_W-1:0] view_width  = 9'd256;
  logic [CFG_W-1:0] view_height = 9'd256;

  pixel_t  pending_pixels [$];
  stroke_t recent_strokes [$];

  bit idling_on      = 1'b1;
  int stall_left     = 0;
  int draw_backlog   = 0;
  int mismatches     = 0;
  int draws_sent     = 0;
  int reads_sent     = 0;
  int pixels_checked = 0;
  int sizes_tried    = 0;

  thick_line_raster_engine dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .start_x_i          (start_x_i),
    .start_y_i          (start_y_i),
    .end_x_i            (end_x_i),
    .end_y_i            (end_y_i),
    .line_color_i       (line_color_i),
    .line_flow_i        (line_flow_i),
    .stamp_half_width_i (stamp_half_width_i),
    .read_x_i           (read_x_i),
    .read_y_i           (read_y_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .pixel_color_o      (pixel_color_o),
    .pixel_flow_o       (pixel_flow_o)
  );

  // Clock generation.
  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Hard limit on the run in case the block hangs.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Timed out with %0d reads unanswered.", pending_pixels.size());
    $display("== FAIL ==");
    $finish;
  end

  // Mismatch bookkeeping.
  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Effective raster size; registers above the store size are clamped.
  function automatic int visible_width();
    return (view_width > DEF_MAX_RASTER_WIDTH) ? int'(DEF_MAX_RASTER_WIDTH)
                                               : int'(view_width);
  endfunction

  function automatic int visible_height();
    return (view_height > DEF_MAX_RASTER_HEIGHT) ? int'(DEF_MAX_RASTER_HEIGHT)
                                                 : int'(view_height);
  endfunction

  // Walk the line and stamp a clipped square of pixels at each point.
  function automatic void paint_line(raster_item_t it);
    int x, y, x1, y1, dx, dy, sx, sy, err, e2, hw, w, h, px, py;
    bit done;
    x  = int'(it.start_x);
    y  = int'(it.start_y);
    x1 = int'(it.end_x);
    y1 = int'(it.end_y);
    hw = int'(it.brush_hw);
    if (hw > int'(DEF_MAX_HALF_WIDTH)) hw = int'(DEF_MAX_HALF_WIDTH);
    w  = visible_width();
    h  = visible_height();
    dx = (x1 > x) ? x1 - x : x - x1;
    dy = (y1 > y) ? y1 - y : y - y1;
    sx = (x < x1) ? 1 : -1;
    sy = (y < y1) ? 1 : -1;
    err = dx - dy;
    done = 1'b0;
    while (!done) begin
      for (py = y - hw; py <= y + hw; py++) begin
        for (px = x - hw; px <= x + hw; px++) begin
          if (px >= 0 && py >= 0 && px < w && py < h) begin
            color_img[py * int'(DEF_MAX_RASTER_WIDTH) + px] = it.color;
            flow_img[py * int'(DEF_MAX_RASTER_WIDTH) + px]  = it.flow;
          end
        end
      end
      if (x == x1 && y == y1) begin
        done = 1'b1;
      end else begin
        e2 = 2 * err;
        if (e2 > -dy) begin
          err -= dy;
          x += sx;
        end
        if (e2 < dx) begin
          err += dx;
          y += sy;
        end
      end
    end
  endfunction

  // Back-end cycles of one draw: every stamped pixel costs one write.
  function automatic int draw_cycles(raster_item_t it);
    int dx, dy, x0, y0, x1, y1, side;
    x0 = int'(it.start_x);
    y0 = int'(it.start_y);
    x1 = int'(it.end_x);
    y1 = int'(it.end_y);
    dx = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy = (y1 > y0) ? y1 - y0 : y0 - y1;
    side = 2 * int'(it.brush_hw) + 1;
    return 1 + ((dx > dy) ? dx : dy) * side * side + side * side;
  endfunction

  // Apply an accepted item to the image; a read queues the pixel it must return.
  function automatic void track_item(raster_item_t it);
    pixel_t want;
    int     addr;
    if (it.command == CMD_DRAW) begin
      paint_line(it);
      draw_backlog += draw_cycles(it);
      draws_sent++;
    end else begin
      want.color = '0;
      want.flow  = '0;
      if (int'(it.read_x) < visible_width() && int'(it.read_y) < visible_height()) begin
        addr       = int'(it.read_y) * int'(DEF_MAX_RASTER_WIDTH) + int'(it.read_x);
        want.color = color_img[addr];
        want.flow  = flow_img[addr];
      end
      pending_pixels.push_back(want);
      // Draws ahead of this read are finished once its result comes back.
      draw_backlog = 0;
      reads_sent++;
    end
  endfunction

  // Offer one item, with an optional idle burst first, and wait for acceptance.
  task automatic send_item(input raster_item_t it);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    command_i          <= it.command;
    start_x_i          <= it.start_x;
    start_y_i          <= it.start_y;
    end_x_i            <= it.end_x;
    end_y_i            <= it.end_y;
    line_color_i       <= it.color;
    line_flow_i        <= it.flow;
    stamp_half_width_i <= it.brush_hw;
    read_x_i           <= it.read_x;
    read_y_i           <= it.read_y;
    in_valid_i         <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    track_item(it);
  endtask

  // Draw item; the read address carries random noise.
  task automatic send_draw(input int x0, input int y0, input int x1, input int y1,
                           input logic [COLOR_W-1:0] color, input logic [FLOW_W-1:0] flow,
                           input int hw);
    raster_item_t it;
    it.command  = CMD_DRAW;
    it.start_x  = COORD_W'(x0);
    it.start_y  = COORD_W'(y0);
    it.end_x    = COORD_W'(x1);
    it.end_y    = COORD_W'(y1);
    it.color    = color;
    it.flow     = flow;
    it.brush_hw = SHW_W'(hw);
    it.read_x   = RD_W'($urandom);
    it.read_y   = RD_W'($urandom);
    send_item(it);
  endtask

  // Read item; the draw fields carry random noise.
  task automatic send_read(input int x, input int y);
    raster_item_t it;
    it.command  = CMD_READ;
    it.start_x  = COORD_W'($urandom);
    it.start_y  = COORD_W'($urandom);
    it.end_x    = COORD_W'($urandom);
    it.end_y    = COORD_W'($urandom);
    it.color    = $urandom;
    it.flow     = FLOW_W'($urandom);
    it.brush_hw = SHW_W'($urandom);
    it.read_x   = RD_W'(x);
    it.read_y   = RD_W'(y);
    send_item(it);
  endtask

  // Hold the input until every read has been answered.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_pixels.size() != 0);
  endtask

  // Drain, then give outstanding draws time to finish so the block is idle.
  task automatic settle();
    drain_results();
    repeat (draw_backlog + 16) @(posedge clk_i);
    draw_backlog = 0;
  endtask

  // Write both raster size registers on consecutive cycles.
  task automatic set_raster(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_RASTER_WIDTH;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_idx_i   <= REG_RASTER_HEIGHT;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    view_width  = w;
    view_height = h;
    sizes_tried++;
  endtask

  // Coordinate a few steps from the base, kept inside the 12-bit range.
  function automatic int near_coord(int base, int span);
    int d;
    d = int'($urandom_range(0, 2 * span)) - span;
    if (base + d > 2047 || base + d < -2048) d = -d;
    return base + d;
  endfunction

  // Saturate a coordinate to a read address.
  function automatic logic [RD_W-1:0] to_addr(int v);
    if (v < 0) return '0;
    if (v > 255) return 8'hFF;
    return RD_W'(v);
  endfunction

  // Random item: mostly short lines near the raster and reads aimed at them.
  function automatic raster_item_t random_item();
    raster_item_t it;
    stroke_t      s;
    int           pick, span, k, reach;
    it.command  = ($urandom_range(0, 99) < 45) ? CMD_DRAW : CMD_READ;
    it.start_x  = COORD_W'($urandom);
    it.start_y  = COORD_W'($urandom);
    it.end_x    = COORD_W'($urandom);
    it.end_y    = COORD_W'($urandom);
    it.color    = $urandom;
    it.flow     = FLOW_W'($urandom);
    it.brush_hw = SHW_W'($urandom);
    it.read_x   = RD_W'($urandom);
    it.read_y   = RD_W'($urandom);
    if (it.command == CMD_DRAW) begin
      pick = int'($urandom_range(0, 99));
      span = 6;
      if (pick < 25) begin
        // Anywhere in the coordinate space, so every coordinate bit toggles.
        s.x0 = int'($urandom_range(0, 4095)) - 2048;
        s.y0 = int'($urandom_range(0, 4095)) - 2048;
        it.brush_hw = SHW_W'($urandom_range(0, 7));
      end else begin
        s.x0 = int'($urandom_range(0, visible_width() + 15)) - 8;
        s.y0 = int'($urandom_range(0, visible_height() + 15)) - 8;
        if (pick < 35) begin
          span = 40;
          it.brush_hw = SHW_W'($urandom_range(0, 2));
        end else if (pick < 55) begin
          it.brush_hw = SHW_W'($urandom_range(3, 7));
        end else begin
          it.brush_hw = SHW_W'($urandom_range(0, 2));
        end
      end
      s.x1 = near_coord(s.x0, span);
      s.y1 = near_coord(s.y0, span);
      s.hw = int'(it.brush_hw);
      it.start_x = COORD_W'(s.x0);
      it.start_y = COORD_W'(s.y0);
      it.end_x   = COORD_W'(s.x1);
      it.end_y   = COORD_W'(s.y1);
      if (pick >= 25) begin
        recent_strokes.push_back(s);
        if (recent_strokes.size() > 16) void'(recent_strokes.pop_front());
      end
    end else if (recent_strokes.size() != 0 && $urandom_range(0, 3) != 0) begin
      // Aim at a point along a recent line, just inside or outside its stamp.
      s = recent_strokes[$urandom_range(0, recent_strokes.size() - 1)];
      k = int'($urandom_range(0, 8));
      reach = s.hw + 1;
      it.read_x = to_addr(s.x0 + (s.x1 - s.x0) * k / 8 + int'($urandom_range(0, 2 * reach))
                          - reach);
      it.read_y = to_addr(s.y0 + (s.y1 - s.y0) * k / 8 + int'($urandom_range(0, 2 * reach))
                          - reach);
    end
    return it;
  endfunction

  // Output stall in random bursts while idling is enabled.
  always @(posedge clk_i) begin
    if (!idling_on) begin
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = int'($urandom_range(0, 4));
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare every accepted result with the oldest pending read.
  always @(posedge clk_i) begin : check_results
    pixel_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("result arrived with no read outstanding");
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_color_o !== want.color)
          report_mismatch($sformatf("pixel_color got %h expected %h",
                                    pixel_color_o, want.color));
        if (pixel_flow_o !== want.flow)
          report_mismatch($sformatf("pixel_flow got %h expected %h",
                                    pixel_flow_o, want.flow));
        pixels_checked++;
      end
    end
  end

  // The store must read as zero once the clearing pass is over.
  task automatic test_reset_contents();
    send_read(0, 0);
    send_read(255, 255);
  endtask

  // Single points, far off-raster lines, clipping at the edges, steep lines.
  task automatic test_directed_draws();
    send_draw(0, 0, 0, 0, 32'hFFFF_FFFF, 8'hFF, 0);
    send_read(0, 0);
    send_draw(-2048, -2048, -2046, -2045, 32'h1357_9BDF, 8'h01, 7);
    send_draw(2047, 2047, 2044, 2047, 32'h2468_ACE0, 8'h02, 7);
    send_draw(-3, -2, 2, 4, 32'hA5A5_5A5A, 8'h5A, 7);
    send_read(9, 11);
    send_read(10, 5);
    send_draw(250, 30, 262, 34, 32'h0000_0000, 8'h80, 1);
    send_read(255, 31);
    send_draw(120, 90, 117, 70, $urandom, FLOW_W'($urandom), 0);
    send_read(118, 80);
  endtask

  // Oversized, empty and single-pixel rasters; contents survive a resize.
  task automatic test_raster_sizes();
    settle();
    set_raster(9'd511, 9'd300);
    send_read(255, 31);
    send_draw(253, 253, 256, 258, 32'hC0FF_EE00, 8'h3C, 2);
    send_read(255, 255);
    settle();
    set_raster(9'd0, 9'd256);
    send_draw(5, 5, 8, 8, 32'hDEAD_0001, 8'h11, 1);
    send_read(0, 0);
    settle();
    set_raster(9'd1, 9'd1);
    send_read(0, 0);
    send_read(1, 0);
    send_draw(0, 0, 3, 0, 32'h0F0F_F0F0, 8'hF0, 0);
    settle();
    set_raster(9'd256, 9'd256);
    send_read(9, 11);
    send_read(6, 6);
  endtask

  // Random phases, each under its own raster size; phase 4 and the last run without idling.
  task automatic test_random_traffic();
    int phase, n;
    logic [CFG_W-1:0] w, h;
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin w = 9'd256; h = 9'd256; end
        1: begin w = 9'd16;  h = 9'd16;  end
        2: begin w = 9'd1;   h = 9'd256; end
        3: begin w = 9'd256; h = 9'd1;   end
        4: begin w = 9'd0;   h = 9'd256; end
        5: begin w = 9'd511; h = 9'd511; end
        6: begin w = 9'd300; h = 9'd40;  end
        7: begin w = 9'd77;  h = 9'd0;   end
        8: begin
          w = CFG_W'($urandom_range(0, 511));
          h = CFG_W'($urandom_range(0, 511));
        end
        default: begin w = 9'd256; h = 9'd256; end
      endcase
      settle();
      set_raster(w, h);
      idling_on = (phase != PHASES - 1) && (phase != 4);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // Midway the sender holds off until every read has been answered.
        if (n == PHASE_ITEMS / 2) drain_results();
        send_item(random_item());
      end
    end
  endtask

  // Test sequence.
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_contents();
    test_directed_draws();
    test_raster_sizes();
    test_random_traffic();
    settle();
    $display("Sent %0d draws and %0d reads over %0d raster sizes.",
             draws_sent, reads_sent, sizes_tried);
    $display("Compared %0d read results, %0d mismatches.", pixels_checked, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
